// ===== design/mhc_pkg.sv =====
// ----------------------------------------------------------------------------
// mhc_pkg
// Shared types and constants for the masked histogram counter.
// ----------------------------------------------------------------------------
package mhc_pkg;

    // Number of bin counters held in the table
    localparam int BIN_DEPTH   = 256;
    localparam int BIN_AW      = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int COUNT_W     = 32;
    localparam int LIMIT_W     = 9;
    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Operation codes carried by an input item
    localparam logic [1:0] OP_COUNT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [LIMIT_W-1:0] BINS_IN_USE_RESET = LIMIT_W'(256);

    // Input item
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] sample;
        logic               keep;
        logic [7:0]         bin_index;
        logic [31:0]        load_value;
    } req_t;

    // Result item
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               counted;
    } rsp_t;

    // Work kind decided by the front
    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_COUNT,
        KIND_READ,
        KIND_WRITE
    } kind_t;

    // Command passed through the queue
    typedef struct packed {
        kind_t              kind;
        logic [BIN_AW-1:0]  addr;
        logic [COUNT_W-1:0] load_value;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } bk_state_t;

endpackage

// ===== design/mhc_front.sv =====
// ----------------------------------------------------------------------------
// mhc_front
// Accepts input items, checks range and mask, and registers one command.
// ----------------------------------------------------------------------------
module mhc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mhc_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  mhc_pkg::req_t               req,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output mhc_pkg::cmd_t               cmd
);
    import mhc_pkg::*;

    logic [LIMIT_W-1:0] bins_in_use_reg;
    logic               cmd_valid_reg;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [31:0]        limit;
    logic               sample_hit;
    logic               index_ok;
    logic               accept;

    // Hold the bin limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg <= BINS_IN_USE_RESET;
        end
        else if (cfg_wr_en)
        begin
            bins_in_use_reg <= cfg_wr_data;
        end
    end

    // Saturate the limit at the table depth
    assign limit = (32'(bins_in_use_reg) > 32'(BIN_DEPTH)) ? 32'(BIN_DEPTH)
                                                          : 32'(bins_in_use_reg);

    // Classify the item
    assign sample_hit = req.keep && !req.sample[31] && ($unsigned(req.sample) < limit);
    assign index_ok   = 32'(req.bin_index) < 32'(BIN_DEPTH);

    always_comb
    begin
        cmd_next.load_value = req.load_value;
        cmd_next.addr       = BIN_AW'(req.bin_index);
        cmd_next.kind       = KIND_NOP;
        case (req.op)
            OP_COUNT:
            begin
                cmd_next.addr = req.sample[BIN_AW-1:0];
                if (sample_hit)
                begin
                    cmd_next.kind = KIND_COUNT;
                end
            end
            OP_READ:
            begin
                if (index_ok)
                begin
                    cmd_next.kind = KIND_READ;
                end
            end
            OP_WRITE:
            begin
                if (index_ok)
                begin
                    cmd_next.kind = KIND_WRITE;
                end
            end
            default:
            begin
                cmd_next.kind = KIND_NOP;
            end
        endcase
    end

    assign req_ready = !cmd_valid_reg || cmd_ready;
    assign accept    = req_valid && req_ready;

    // Hold the classified command until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            cmd_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== design/mhc_queue.sv =====
// ----------------------------------------------------------------------------
// mhc_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mhc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mhc_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output mhc_pkg::cmd_t pop_cmd
);
    import mhc_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] wr_ptr_reg;
    logic [QUEUE_PW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] fill_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = fill_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                  : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                  : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/mhc_back.sv =====
// ----------------------------------------------------------------------------
// mhc_back
// Bin table with read-modify-write sequencer and result register.
// ----------------------------------------------------------------------------
module mhc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  mhc_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mhc_pkg::rsp_t rsp
);
    import mhc_pkg::*;

    logic [COUNT_W-1:0]   bin_mem [BIN_DEPTH];
    logic [BIN_DEPTH-1:0] bin_vld_reg;
    logic [COUNT_W-1:0]   rd_data_reg;
    logic                 rd_vld_reg;
    cmd_t                 cur_reg;
    bk_state_t            state_reg;
    bk_state_t            state_next;
    logic                 slot_free;
    logic                 wr_en;
    logic                 rsp_load;
    logic [COUNT_W-1:0]   old_count;
    logic [COUNT_W-1:0]   wr_data;
    rsp_t                 rsp_next;
    rsp_t                 rsp_reg;
    logic                 rsp_valid_reg;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        wr_en    = 1'b0;
        rsp_load = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_pop = cmd_valid && slot_free;
            end
            BK_EXEC:
            begin
                rsp_load = 1'b1;
                wr_en    = (cur_reg.kind == KIND_COUNT) || (cur_reg.kind == KIND_WRITE);
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the command and read its bin
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg     <= cmd;
            rd_data_reg <= bin_mem[cmd.addr];
            rd_vld_reg  <= bin_vld_reg[cmd.addr];
        end
    end

    // Bins never written since reset read as zero
    assign old_count = rd_vld_reg ? rd_data_reg : '0;
    assign wr_data   = (cur_reg.kind == KIND_WRITE) ? cur_reg.load_value
                                                   : old_count + 1'b1;

    always_comb
    begin
        rsp_next.count   = '0;
        rsp_next.counted = 1'b0;
        case (cur_reg.kind)
            KIND_COUNT:
            begin
                rsp_next.count   = wr_data;
                rsp_next.counted = 1'b1;
            end
            KIND_READ:
            begin
                rsp_next.count = old_count;
            end
            default:
            begin
                rsp_next.count = '0;
            end
        endcase
    end

    // Write back the bin
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[cur_reg.addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            bin_vld_reg[cur_reg.addr] <= 1'b1;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A popped command is carried out in the very next cycle
    a_pop_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == BK_EXEC))
        else $error("command popped but not executed next cycle");

    // The result slot is never overwritten while still full
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> $past(slot_free))
        else $error("result loaded over an untaken result");

    // No table write outside the execute step
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == BK_EXEC) && $past(cmd_pop))
        else $error("bin write outside execute step");

endmodule

// ===== design/masked_histogram_counter_top.sv =====
// ----------------------------------------------------------------------------
// masked_histogram_counter_top
// Masked 1-D histogram over a table of 32-bit bin counters.
//
// Each item yields one result. The front classifies an item in the cycle it
// is accepted and registers a command; a two-entry queue feeds the back,
// which spends two steps on every command (registered table read, then
// update and result) and takes no new command until the last one is done.
// The two-step read-modify-write of the single-port bin table is the cause.
// Bins start at zero after reset through per-bin valid flags, so no clearing
// pass is needed and items are taken from the first cycle. bins_in_use is to
// be written through cfg_wr_en/cfg_wr_data only while the block is idle; the
// block does not enforce this. Values above the table depth count every bin.
// ----------------------------------------------------------------------------
module masked_histogram_counter_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mhc_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  mhc_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output mhc_pkg::rsp_t               rsp
);
    import mhc_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // Accept and classify
    mhc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // Decouple front and back
    mhc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(cmd_valid),
        .push_ready(cmd_ready),
        .push_cmd  (cmd),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_cmd   (q_cmd)
    );

    // Update the table and deliver results
    mhc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(q_valid),
        .cmd_pop  (q_pop),
        .cmd      (q_cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

endmodule

// ===== verif/masked_histogram_counter_top_tb.sv =====
// ----------------------------------------------------------------------------
// masked_histogram_counter_top_tb
// Checks the masked histogram counter against a behavioural bin table kept in
// the bench. Directed items cover the sample and bin-limit corners, preloads
// and counter wrap. Random traffic then runs under several bin limits and
// handshake idling patterns. Every result is compared in order with the count
// and flag that the bench's own table predicts.
// ----------------------------------------------------------------------------
module masked_histogram_counter_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mhc_pkg::*;

    // Op code with no defined action; the block must answer it with zeroes
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_BLOCK = 192;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wr_data = '0;
    logic                req_valid   = 1'b0;
    logic                req_ready;
    req_t                req         = '0;
    logic                rsp_valid;
    logic                rsp_ready   = 1'b0;
    rsp_t                rsp;

    // Bench copy of the bin table and the bin limit
    logic [COUNT_W-1:0]  bin_table [BIN_DEPTH];
    logic [LIMIT_W-1:0]  bins_limit;
    rsp_t                awaited_bin_reports [$];
    rsp_t                next_report;
    int unsigned         hot_bins [4];

    int                  req_idle_pct = 0;
    int                  rsp_stall_pct = 0;
    int unsigned         items_sent = 0;
    int unsigned         reports_checked = 0;
    int unsigned         samples_counted = 0;
    int unsigned         limits_applied = 0;
    int unsigned         mismatches = 0;

    masked_histogram_counter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

    // Clock: 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the result side at the current rate
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // Compare each accepted result with the oldest awaited report
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_bin_reports.size() == 0)
            begin
                $error("result with no item outstanding: count %0h counted %0b",
                       rsp.count, rsp.counted);
                mismatches++;
            end
            else
            begin
                next_report = awaited_bin_reports.pop_front();
                reports_checked++;
                if (rsp.count !== next_report.count)
                begin
                    $error("count: expected %08h, got %08h", next_report.count, rsp.count);
                    mismatches++;
                end
                if (rsp.counted !== next_report.counted)
                begin
                    $error("counted: expected %0b, got %0b",
                           next_report.counted, rsp.counted);
                    mismatches++;
                end
            end
        end
    end

    // Apply one item to the bench table and return the report it should give
    function automatic rsp_t apply_to_histogram(req_t it);
        rsp_t        r;
        int unsigned span;
        r = '0;
        span = (bins_limit > BIN_DEPTH) ? BIN_DEPTH : bins_limit;
        case (it.op)
            OP_COUNT:
            begin
                if (it.keep && !it.sample[31] && $unsigned(it.sample) < span)
                begin
                    bin_table[it.sample[BIN_AW-1:0]] = bin_table[it.sample[BIN_AW-1:0]] + 1;
                    r.count   = bin_table[it.sample[BIN_AW-1:0]];
                    r.counted = 1'b1;
                end
            end
            OP_READ:  r.count = bin_table[it.bin_index];
            OP_WRITE: bin_table[it.bin_index] = it.load_value;
            default:  ;
        endcase
        return r;
    endfunction

    // Item builders; unused fields carry random bits
    function automatic req_t make_item(logic [1:0] op, logic [31:0] smp, logic keep,
                                       logic [7:0] idx, logic [31:0] load);
        req_t it;
        it.op         = op;
        it.sample     = smp;
        it.keep       = keep;
        it.bin_index  = idx;
        it.load_value = load;
        return it;
    endfunction

    function automatic req_t count_item(logic [31:0] smp, logic keep);
        return make_item(OP_COUNT, smp, keep, 8'($urandom), $urandom);
    endfunction

    function automatic req_t read_item(logic [7:0] idx);
        return make_item(OP_READ, $urandom, 1'($urandom), idx, $urandom);
    endfunction

    function automatic req_t write_item(logic [7:0] idx, logic [31:0] load);
        return make_item(OP_WRITE, $urandom, 1'($urandom), idx, load);
    endfunction

    // Offer one item, idling first at the current rate, and predict on acceptance
    task automatic push_histogram_item(input req_t it);
        rsp_t r;
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        r = apply_to_histogram(it);
        if (r.counted)
            samples_counted++;
        awaited_bin_reports.push_back(r);
        items_sent++;
    endtask

    // Drop valid and wait until every awaited report has come back
    task automatic wait_until_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_bin_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_idling(input int req_pct, input int rsp_pct);
        req_idle_pct  = req_pct;
        rsp_stall_pct = rsp_pct;
    endtask

    // Write the bin limit while the block is idle
    task automatic set_bins_in_use(input logic [LIMIT_W-1:0] value);
        wait_until_idle();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        bins_limit = value;
        limits_applied++;
    endtask

    // Bins read back as zero straight after reset
    task automatic test_reset_state();
        push_histogram_item(read_item(8'd0));
        push_histogram_item(read_item(8'd255));
    endtask

    // Sample range edges, negative values and a cleared keep flag
    task automatic test_sample_edges();
        push_histogram_item(count_item(32'd0, 1'b1));
        push_histogram_item(count_item(32'd0, 1'b1));
        push_histogram_item(count_item(32'd255, 1'b1));
        push_histogram_item(count_item(32'd256, 1'b1));
        push_histogram_item(count_item(32'hFFFF_FFFF, 1'b1));
        push_histogram_item(count_item(32'h8000_0000, 1'b1));
        push_histogram_item(count_item(32'h7FFF_FFFF, 1'b1));
        push_histogram_item(count_item(32'd5, 1'b0));
        push_histogram_item(read_item(8'd0));
    endtask

    // Preload bins, wrap a counter and send the unused op code
    task automatic test_preload_and_wrap();
        push_histogram_item(write_item(8'd7, 32'hFFFF_FFFF));
        push_histogram_item(count_item(32'd7, 1'b1));
        push_histogram_item(count_item(32'd7, 1'b1));
        push_histogram_item(read_item(8'd7));
        push_histogram_item(write_item(8'd200, 32'hAAAA_5555));
        push_histogram_item(read_item(8'd200));
        push_histogram_item(make_item(OP_UNUSED, 32'd9, 1'b1, 8'd9, 32'h1234_5678));
        push_histogram_item(read_item(8'd9));
    endtask

    // Zero limit, a single bin, and limits above the table depth
    task automatic test_bin_limits();
        set_bins_in_use(9'd0);
        push_histogram_item(count_item(32'd0, 1'b1));
        set_bins_in_use(9'd1);
        push_histogram_item(count_item(32'd0, 1'b1));
        push_histogram_item(count_item(32'd1, 1'b1));
        set_bins_in_use(9'd511);
        push_histogram_item(count_item(32'd255, 1'b1));
        push_histogram_item(count_item(32'd256, 1'b1));
        set_bins_in_use(9'd257);
        push_histogram_item(count_item(32'd255, 1'b1));
    endtask

    // Random item biased towards a few hot bins so counts build up and wrap
    function automatic req_t random_histogram_item(int unsigned span);
        req_t        it;
        int unsigned pick;
        it = make_item(OP_COUNT, $urandom, ($urandom_range(0, 9) != 0),
                       8'($urandom), $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 58)
            it.op = OP_COUNT;
        else if (pick < 78)
            it.op = OP_READ;
        else if (pick < 94)
            it.op = OP_WRITE;
        else
            it.op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            it.sample = hot_bins[$urandom_range(0, 3)];
        else if (pick < 70)
            it.sample = $urandom_range(0, span + 3);
        else if (pick < 88)
            it.sample = -$signed(32'($urandom_range(1, 300)));
        if ($urandom_range(0, 1) == 0)
            it.bin_index = 8'(hot_bins[$urandom_range(0, 3)]);
        if ($urandom_range(0, 99) < 30)
            it.load_value = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        return it;
    endfunction

    // Blocks of random traffic, each under its own limit; pairs of blocks share one idling pattern
    task automatic test_random_traffic();
        logic [LIMIT_W-1:0] limits [6];
        int unsigned        span;
        limits[0] = 9'd256;
        limits[1] = 9'd0;
        limits[2] = 9'd511;
        limits[3] = 9'd1;
        limits[4] = 9'($urandom_range(2, 255));
        limits[5] = 9'($urandom_range(257, 510));
        for (int blk = 0; blk < 6; blk++)
        begin
            case (blk / 2)
                0:       set_idling(33, 55);
                1:       set_idling(55, 33);
                default: set_idling(0, 0);
            endcase
            set_bins_in_use(limits[blk]);
            span = (limits[blk] > BIN_DEPTH) ? BIN_DEPTH : limits[blk];
            hot_bins[0] = 0;
            hot_bins[1] = (span > 0) ? span - 1 : 0;
            hot_bins[2] = $urandom_range(0, (span > 0) ? span - 1 : 0);
            hot_bins[3] = $urandom_range(0, 255);
            repeat (ITEMS_PER_BLOCK)
                push_histogram_item(random_histogram_item(span));
        end
    endtask

    // Main sequence
    initial
    begin
        for (int i = 0; i < BIN_DEPTH; i++)
            bin_table[i] = '0;
        bins_limit = BINS_IN_USE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(33, 55);
        test_reset_state();
        test_sample_edges();
        test_preload_and_wrap();
        test_bin_limits();
        test_random_traffic();
        wait_until_idle();
        repeat (10) @(posedge clk);

        $display("Covered %0d items, %0d results compared, %0d samples counted,",
                 items_sent, reports_checked, samples_counted);
        $display("under %0d bin-limit settings and three idling patterns.", limits_applied);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
